/* rtl/swsm_pkg.sv */
// shared types and constants for the sliding window sum and mean block
`timescale 1ns / 1ps
package swsm_pkg;

	// data word width of samples, sums and means
	localparam int unsigned DATA_W = 32;

	// default window depth
	localparam int unsigned WINDOW_SIZE_DEF = 16;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SUB,
		ST_KICK,
		ST_WAIT,
		ST_OUT
	} swsm_state_t;

	// status of the iterative divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/swsm_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module swsm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/swsm_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module swsm_div #(
	parameter int unsigned CNT_W = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [swsm_pkg::DATA_W-1:0] dividend,
	input  logic [CNT_W-1:0]          divisor,
	output logic [swsm_pkg::DATA_W-1:0] quotient,
	output swsm_pkg::div_stat_t       stat
);
	import swsm_pkg::*;

	localparam int unsigned STEP_W = $clog2(DATA_W);

	logic [DATA_W-1:0] quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    cand;
	logic [CNT_W:0]    diff;
	logic              ge;

	// trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		cand = {rem_q, quo_q[DATA_W-1]};
		diff = cand - {1'b0, divisor};
		ge   = (cand >= {1'b0, divisor});
	end

	// control: step counter, busy and done flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient shifts in, remainder restores on a failed subtract
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DATA_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : cand[CNT_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* rtl/sliding_window_sum_mean.sv */
// top level: ring of samples, running total, sequencer and result register
`timescale 1ns / 1ps
// Moving sum and mean over the last WINDOW_SIZE 32-bit unsigned words. Each accepted
// word goes into a ring memory, replacing the oldest word once the window is full;
// a running total (modulo 2^32) is kept by adding the new word and subtracting the
// replaced one. One result word follows every input word: the wrapped sum, the sum
// divided by the held count (truncated) and the held count itself. After acceptance a
// word passes through the add with the ring read, the subtract with the ring write,
// the divider start, the wait for the restoring divider, which produces one quotient
// bit per cycle, the result load, which waits until the previous result has left the
// output register, and the return to idle, where the next word can be accepted.
// in_stall stays high while a word is being worked on. A finished result sits in an
// output register, so the next word is taken even while the result is still stalled
// downstream.
module sliding_window_sum_mean #(
	parameter int unsigned WINDOW_SIZE = swsm_pkg::WINDOW_SIZE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [swsm_pkg::DATA_W-1:0]          value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [swsm_pkg::DATA_W-1:0]          window_sum,
	output logic [swsm_pkg::DATA_W-1:0]          window_mean,
	output logic [$clog2(WINDOW_SIZE+1)-1:0]     held_count
);
	import swsm_pkg::*;

	localparam int unsigned IDX_W = $clog2(WINDOW_SIZE);
	localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);

	swsm_state_t       state_q;
	swsm_state_t       state_nxt;

	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] total_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  next_slot_q;
	logic              full;

	logic [DATA_W-1:0] rd_data;
	logic [DATA_W-1:0] quotient;
	div_stat_t         div_stat;

	logic              ram_re;
	logic              add_en;
	logic              sub_en;
	logic              div_start;
	logic              out_load;

	logic              out_valid_q;
	logic [DATA_W-1:0] sum_q;
	logic [DATA_W-1:0] mean_q;
	logic [CNT_W-1:0]  count_q;

	assign full = (fill_q == CNT_W'(WINDOW_SIZE));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_ADD;
				end
			end
			ST_ADD:  state_nxt = ST_SUB;
			ST_SUB:  state_nxt = ST_KICK;
			ST_KICK: state_nxt = ST_WAIT;
			ST_WAIT: begin
				if (div_stat.done) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		ram_re    = 1'b0;
		add_en    = 1'b0;
		sub_en    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_ADD: begin
				ram_re = 1'b1;
				add_en = 1'b1;
			end
			ST_SUB:  sub_en = 1'b1;
			ST_KICK: div_start = 1'b1;
			ST_WAIT: ;
			ST_OUT:  out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			value_q <= value;
		end
	end

	// running total, fill count and write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			fill_q      <= '0;
			next_slot_q <= '0;
		end else begin
			if (add_en) begin
				total_q <= total_q + value_q;
			end
			if (sub_en) begin
				if (full) begin
					total_q <= total_q - rd_data;
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
				if (next_slot_q == IDX_W'(WINDOW_SIZE - 1)) begin
					next_slot_q <= '0;
				end else begin
					next_slot_q <= next_slot_q + IDX_W'(1);
				end
			end
		end
	end

	// ring of held samples, the slot read is the one about to be overwritten
	swsm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (WINDOW_SIZE)
	) u_ring (
		.clk   (clk),
		.we    (sub_en),
		.waddr (next_slot_q),
		.wdata (value_q),
		.re    (ram_re),
		.raddr (next_slot_q),
		.rdata (rd_data)
	);

	// mean of the wrapped sum
	swsm_div #(
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q),
		.divisor  (fill_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sum_q   <= total_q;
			mean_q  <= quotient;
			count_q <= fill_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign window_sum  = sum_q;
	assign window_mean = mean_q;
	assign held_count  = count_q;

	// fill count never passes the window depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_SIZE))
		else $error("fill count beyond window depth");

	// until the window is full the write pointer equals the fill count
	a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (CNT_W'(next_slot_q) == fill_q))
		else $error("write pointer out of step with fill count");

	// the divider finishes only while the sequencer waits for it
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_WAIT))
		else $error("divider finished outside wait state");

	// the divider is never restarted while busy
	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	// a result is loaded only with at least one sample held
	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (count_q != '0))
		else $error("result loaded with empty window");

endmodule
